[rtl/http_chunked_body_decoder_unit_defines.svh]
// Assertion macros for the chunked body decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define HCBD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define HCBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hcbd_pkg.sv]
// Types and constants for the chunked body decoder.
`default_nettype none

package hcbd_pkg;

    localparam int SIZE_LINE_MAX_DEF    = 64;
    localparam int TRAILER_LINE_MAX_DEF = 8192;
    localparam int COUNT_WIDTH_DEF      = 32;

    localparam logic [31:0] MAX_BODY_RESET = 32'd10485760;

    localparam int          CFG_ADDR_W    = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_BODY = 3'd0;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_VT  = 8'h0B;
    localparam logic [7:0] CHAR_FF  = 8'h0C;

    localparam int HEX_RADIX_BITS = 4;   // radix 16

    typedef enum logic [2:0] {
        STATUS_MORE     = 3'd0,
        STATUS_COMPLETE = 3'd1,
        STATUS_MALFORM  = 3'd2,
        STATUS_LARGE    = 3'd3,
        STATUS_IDLE     = 3'd4
    } status_t;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_SIZE   = 11'b000_0000_0010,
        ST_DATA   = 11'b000_0000_0100,
        ST_DCR    = 11'b000_0000_1000,
        ST_DLF    = 11'b000_0001_0000,
        ST_TSTART = 11'b000_0010_0000,
        ST_TCR    = 11'b000_0100_0000,
        ST_TLINE  = 11'b000_1000_0000,
        ST_DONE   = 11'b001_0000_0000,
        ST_MALF   = 11'b010_0000_0000,
        ST_LARGE  = 11'b100_0000_0000
    } stage_t;

    typedef enum logic [1:0] {
        PH_BLANK  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_STOP   = 2'd2
    } phase_t;

    // Classification of one size-line character
    typedef struct packed {
        logic       is_hex;
        logic       is_blank;
        logic [3:0] digit;
    } char_class_t;

    function automatic char_class_t classify(input logic [7:0] b);
        char_class_t c;
        c.is_blank = (b == CHAR_SP) || (b == CHAR_TAB) || (b == CHAR_VT) ||
                     (b == CHAR_FF) || (b == CHAR_CR);
        c.is_hex   = 1'b1;
        c.digit    = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            c.digit = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            c.digit = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            c.digit = 4'(b - 8'h37);
        end else begin
            c.is_hex = 1'b0;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/hcbd_size_parse.sv]
// Size-line digit parser: blank skip, hex accumulate with saturation, stop phase.
`default_nettype none

module hcbd_size_parse #(
    parameter int COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic [7:0]             byte_value,
    input  wire hcbd_pkg::phase_t       phase,
    input  wire logic [COUNT_WIDTH:0]   size_accum,
    output hcbd_pkg::phase_t            phase_next,
    output logic [COUNT_WIDTH:0]        size_accum_next
);

    localparam int RB = hcbd_pkg::HEX_RADIX_BITS;

    hcbd_pkg::char_class_t cls;
    logic                  will_ovf;
    logic [COUNT_WIDTH:0]  shifted;

    assign cls      = hcbd_pkg::classify(byte_value);
    // top nibble of the in-range value must be clear for the shift to fit
    assign will_ovf = |size_accum[COUNT_WIDTH-1 -: RB];
    assign shifted  = {1'b0, size_accum[COUNT_WIDTH-1-RB:0], cls.digit};

    always_comb begin
        phase_next      = phase;
        size_accum_next = size_accum;
        if (phase != hcbd_pkg::PH_STOP) begin
            priority if (phase == hcbd_pkg::PH_BLANK && cls.is_blank) begin
                phase_next = phase;
            end else if (cls.is_hex) begin
                phase_next = hcbd_pkg::PH_DIGITS;
                if (!size_accum[COUNT_WIDTH]) begin
                    if (will_ovf) begin
                        size_accum_next = {1'b1, {COUNT_WIDTH{1'b0}}};
                    end else begin
                        size_accum_next = shifted;
                    end
                end
            end else begin
                phase_next = hcbd_pkg::PH_STOP;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/http_chunked_body_decoder_unit.sv]
// Top level of the HTTP/1.1 chunked transfer body decoder.
// Usage:
//   s_ channel: one request per received body byte. s_tuser = 1 starts a new
//   chunked body (s_tdata ignored), s_tuser = 0 carries one byte in s_tdata.
//   m_ channel: exactly one result per request, in order. m_tuser flags a
//   payload byte in m_tdata[7:0]; m_tdata[10:8] carries the status
//   (0 need more, 1 complete, 2 malformed, 3 too large, 4 idle).
//   APB port: register 0 at byte address 0 is max_body.
// Timing:
//   The result is registered: the decode state and the result register both load
//   on the edge that accepts a request. Throughput is one byte per cycle,
//   set by the single result register whose ready is passed back to the
//   input whenever it is empty or being drained.
// Reset (aresetn low, synchronous): the decoder goes idle, max_body returns
//   to 10485760, the result register is emptied.
// Stall: while m_tready is low and a result is held, s_tready is low and the
//   decode state does not move.
`default_nettype none

module http_chunked_body_decoder_unit #(
    parameter int SIZE_LINE_MAX    = hcbd_pkg::SIZE_LINE_MAX_DEF,
    parameter int TRAILER_LINE_MAX = hcbd_pkg::TRAILER_LINE_MAX_DEF,
    parameter int COUNT_WIDTH      = hcbd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic        s_tuser,   // [0] req_type

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] data_byte, [10:8] status, rest zero
    output logic             m_tuser,   // [0] is_data

    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [hcbd_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    `include "http_chunked_body_decoder_unit_defines.svh"

    localparam int LC_TOP  = (SIZE_LINE_MAX > TRAILER_LINE_MAX + 1) ?
                             SIZE_LINE_MAX : TRAILER_LINE_MAX + 1;
    localparam int LC_W    = $clog2(LC_TOP + 1);
    localparam int CMP_W   = (COUNT_WIDTH + 1 > 32) ? COUNT_WIDTH + 1 : 32;

    localparam logic [LC_W-1:0] SIZE_LIMIT  = LC_W'(SIZE_LINE_MAX - 1);
    localparam logic [LC_W-1:0] TRAIL_LIMIT = LC_W'(TRAILER_LINE_MAX);

    // ---------------- configuration ----------------
    logic [31:0] max_body_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == hcbd_pkg::REG_MAX_BODY) ? max_body_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_body_reg <= hcbd_pkg::MAX_BODY_RESET;
        end else if (cfg_wr && paddr == hcbd_pkg::REG_MAX_BODY) begin
            max_body_reg <= pwdata;
        end
    end

    // ---------------- decode state ----------------
    hcbd_pkg::stage_t       stage_reg, stage_next;
    hcbd_pkg::phase_t       phase_reg, phase_next;
    logic [COUNT_WIDTH:0]   size_accum_reg, size_accum_next;
    logic [LC_W-1:0]        line_count_reg, line_count_next;
    logic [COUNT_WIDTH-1:0] chunk_left_reg, chunk_left_next;
    logic [COUNT_WIDTH-1:0] body_total_reg, body_total_next;

    logic                   m_tvalid_reg;
    logic [7:0]             data_byte_reg, data_byte_next;
    logic                   is_data_reg, is_data_next;
    hcbd_pkg::status_t      status_reg, status_next;

    hcbd_pkg::phase_t       pp_phase;
    logic [COUNT_WIDTH:0]   pp_accum;

    logic                   s_fire;
    logic [LC_W-1:0]        lc_inc;
    logic [CMP_W-1:0]       sum_ext;
    logic [CMP_W-1:0]       max_ext;
    logic                   too_large;
    logic [COUNT_WIDTH-1:0] chunk_dec;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign lc_inc   = line_count_reg + LC_W'(1);
    assign chunk_dec = chunk_left_reg - COUNT_WIDTH'(1);

    assign sum_ext  = CMP_W'(body_total_reg) + CMP_W'(size_accum_reg);
    assign max_ext  = CMP_W'(max_body_reg);
    assign too_large = size_accum_reg[COUNT_WIDTH] || sum_ext[COUNT_WIDTH] ||
                       (sum_ext > max_ext);

    hcbd_size_parse #(
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_size_parse (
        .byte_value      (s_tdata),
        .phase           (phase_reg),
        .size_accum      (size_accum_reg),
        .phase_next      (pp_phase),
        .size_accum_next (pp_accum)
    );

    always_comb begin
        stage_next      = stage_reg;
        phase_next      = phase_reg;
        size_accum_next = size_accum_reg;
        line_count_next = line_count_reg;
        chunk_left_next = chunk_left_reg;
        body_total_next = body_total_reg;
        data_byte_next  = 8'd0;
        is_data_next    = 1'b0;
        status_next     = hcbd_pkg::STATUS_MORE;

        if (s_tuser) begin
            stage_next      = hcbd_pkg::ST_SIZE;
            phase_next      = hcbd_pkg::PH_BLANK;
            size_accum_next = '0;
            line_count_next = '0;
            chunk_left_next = '0;
            body_total_next = '0;
        end else begin
            unique case (stage_reg)
                hcbd_pkg::ST_SIZE: begin
                    if (s_tdata == hcbd_pkg::CHAR_LF) begin
                        if (too_large) begin
                            stage_next  = hcbd_pkg::ST_LARGE;
                            status_next = hcbd_pkg::STATUS_LARGE;
                        end else begin
                            chunk_left_next = size_accum_reg[COUNT_WIDTH-1:0];
                            stage_next = (size_accum_reg == '0) ? hcbd_pkg::ST_TSTART
                                                                : hcbd_pkg::ST_DATA;
                        end
                        phase_next      = hcbd_pkg::PH_BLANK;
                        size_accum_next = '0;
                        line_count_next = '0;
                    end else begin
                        line_count_next = lc_inc;
                        if (lc_inc >= SIZE_LIMIT) begin
                            stage_next  = hcbd_pkg::ST_MALF;
                            status_next = hcbd_pkg::STATUS_MALFORM;
                        end else begin
                            phase_next      = pp_phase;
                            size_accum_next = pp_accum;
                        end
                    end
                end
                hcbd_pkg::ST_DATA: begin
                    data_byte_next  = s_tdata;
                    is_data_next    = 1'b1;
                    body_total_next = body_total_reg + COUNT_WIDTH'(1);
                    chunk_left_next = chunk_dec;
                    if (chunk_dec == '0) begin
                        stage_next = hcbd_pkg::ST_DCR;
                    end
                end
                hcbd_pkg::ST_DCR: begin
                    if (s_tdata == hcbd_pkg::CHAR_CR) begin
                        stage_next = hcbd_pkg::ST_DLF;
                    end else begin
                        stage_next  = hcbd_pkg::ST_MALF;
                        status_next = hcbd_pkg::STATUS_MALFORM;
                    end
                end
                hcbd_pkg::ST_DLF: begin
                    if (s_tdata == hcbd_pkg::CHAR_LF) begin
                        stage_next      = hcbd_pkg::ST_SIZE;
                        phase_next      = hcbd_pkg::PH_BLANK;
                        size_accum_next = '0;
                        line_count_next = '0;
                    end else begin
                        stage_next  = hcbd_pkg::ST_MALF;
                        status_next = hcbd_pkg::STATUS_MALFORM;
                    end
                end
                hcbd_pkg::ST_TSTART: begin
                    if (s_tdata == hcbd_pkg::CHAR_CR) begin
                        stage_next = hcbd_pkg::ST_TCR;
                    end else if (s_tdata != hcbd_pkg::CHAR_LF) begin
                        stage_next      = hcbd_pkg::ST_TLINE;
                        line_count_next = LC_W'(1);
                    end
                end
                hcbd_pkg::ST_TCR: begin
                    if (s_tdata == hcbd_pkg::CHAR_LF) begin
                        stage_next  = hcbd_pkg::ST_DONE;
                        status_next = hcbd_pkg::STATUS_COMPLETE;
                    end else begin
                        // lone CR opens an ordinary trailer line
                        stage_next      = hcbd_pkg::ST_TLINE;
                        line_count_next = LC_W'(2);
                    end
                end
                hcbd_pkg::ST_TLINE: begin
                    if (s_tdata == hcbd_pkg::CHAR_LF) begin
                        stage_next      = hcbd_pkg::ST_TSTART;
                        line_count_next = '0;
                    end else if (line_count_reg >= TRAIL_LIMIT) begin
                        line_count_next = lc_inc;
                        stage_next      = hcbd_pkg::ST_MALF;
                        status_next     = hcbd_pkg::STATUS_MALFORM;
                    end else begin
                        line_count_next = lc_inc;
                    end
                end
                hcbd_pkg::ST_DONE:  status_next = hcbd_pkg::STATUS_COMPLETE;
                hcbd_pkg::ST_MALF:  status_next = hcbd_pkg::STATUS_MALFORM;
                hcbd_pkg::ST_LARGE: status_next = hcbd_pkg::STATUS_LARGE;
                default:            status_next = hcbd_pkg::STATUS_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg      <= hcbd_pkg::ST_IDLE;
            phase_reg      <= hcbd_pkg::PH_BLANK;
            size_accum_reg <= '0;
            line_count_reg <= '0;
            chunk_left_reg <= '0;
            body_total_reg <= '0;
        end else if (s_fire) begin
            stage_reg      <= stage_next;
            phase_reg      <= phase_next;
            size_accum_reg <= size_accum_next;
            line_count_reg <= line_count_next;
            chunk_left_reg <= chunk_left_next;
            body_total_reg <= body_total_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            data_byte_reg <= data_byte_next;
            is_data_reg   <= is_data_next;
            status_reg    <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, status_reg, data_byte_reg};
    assign m_tuser  = is_data_reg;

    // ---------------- checks ----------------
    `HCBD_ASSERT_NOW(a_stage_onehot, aclk, aresetn, 1'b1, $onehot(stage_reg),
        "decode stage lost its one-hot code")
    `HCBD_ASSERT_NOW(a_data_has_left, aclk, aresetn, stage_reg == hcbd_pkg::ST_DATA,
        chunk_left_reg != '0, "data stage entered with no bytes left in chunk")
    `HCBD_ASSERT_NOW(a_data_status, aclk, aresetn, m_tvalid_reg && is_data_reg,
        status_reg == hcbd_pkg::STATUS_MORE, "payload byte carried a final status")
    `HCBD_ASSERT_NEXT(a_start_clears, aclk, aresetn, s_fire && s_tuser,
        m_tvalid_reg && stage_reg == hcbd_pkg::ST_SIZE && body_total_reg == '0 &&
        status_reg == hcbd_pkg::STATUS_MORE, "start request did not reset the decoder")

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking bench for the chunked body decoder: byte stream in, decoded bytes and status out.
`timescale 1ns / 1ps

module tb_top;
    import hcbd_pkg::*;

    localparam int          STALL_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [32:0] SIZE_LIMIT  = 33'h0_FFFF_FFFF;

    typedef struct packed {
        logic       start;
        logic [7:0] b;
    } byte_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_data;
        status_t    status;
    } dec_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    http_chunked_body_decoder_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    byte_req_t   pending_q[$];
    dec_result_t exp_result_q[$];
    logic [7:0]  body_q[$];

    int   n_fail      = 0;
    int   n_queued    = 0;
    int   n_results   = 0;
    int   idle_cycles = 0;
    int   in_gap      = 0;
    int   out_gap     = 0;
    int   hold_left   = 0;
    bit   held_once   = 1'b0;
    bit   steady      = 1'b0;
    bit   in_taken    = 1'b0;
    bit   out_taken   = 1'b0;

    logic [7:0] blanks [5] = '{CHAR_SP, CHAR_TAB, CHAR_VT, CHAR_FF, CHAR_CR};
    string      hex_chars  = "0123456789abcdefABCDEF";

    // Decoder state as predicted from the accepted requests
    stage_t      dec_stage;
    logic [32:0] dec_size;
    phase_t      dec_phase;
    logic [13:0] dec_line;
    logic [31:0] dec_chunk_left;
    logic [31:0] dec_total;
    logic [31:0] dec_max_body;

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - int'("0");
        if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
        if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
        return -1;
    endfunction

    function automatic bit is_size_blank(input logic [7:0] b);
        return b == CHAR_SP || b == CHAR_TAB || b == CHAR_VT || b == CHAR_FF || b == CHAR_CR;
    endfunction

    function automatic void clear_size_line();
        dec_size  = '0;
        dec_phase = PH_BLANK;
        dec_line  = '0;
    endfunction

    function automatic void reset_decoder();
        dec_max_body   = MAX_BODY_RESET;
        dec_stage      = ST_IDLE;
        clear_size_line();
        dec_chunk_left = '0;
        dec_total      = '0;
    endfunction

    function automatic dec_result_t chunk_decode_step(input logic start, input logic [7:0] b);
        dec_result_t r;
        logic [33:0] sum;
        logic [63:0] grown;
        int          d;
        r = '{data: 8'h00, is_data: 1'b0, status: STATUS_MORE};
        if (start) begin
            clear_size_line();
            dec_chunk_left = '0;
            dec_total      = '0;
            dec_stage      = ST_SIZE;
            return r;
        end
        case (dec_stage)
            ST_SIZE: begin
                if (b == CHAR_LF) begin
                    sum = {1'b0, dec_size} + {2'b00, dec_total};
                    if (dec_size > SIZE_LIMIT || sum > {2'b00, dec_max_body} ||
                        sum > {1'b0, SIZE_LIMIT}) begin
                        dec_stage = ST_LARGE;
                        r.status  = STATUS_LARGE;
                    end else begin
                        dec_chunk_left = dec_size[31:0];
                        dec_stage      = (dec_size != '0) ? ST_DATA : ST_TSTART;
                    end
                    clear_size_line();
                end else begin
                    dec_line = dec_line + 14'd1;
                    if (dec_line >= SIZE_LINE_MAX_DEF - 1) begin
                        dec_stage = ST_MALF;
                        r.status  = STATUS_MALFORM;
                    end else if (dec_phase != PH_STOP &&
                                 !(dec_phase == PH_BLANK && is_size_blank(b))) begin
                        d = hex_digit(b);
                        if (d >= 0) begin
                            dec_phase = PH_DIGITS;
                            // once saturated the size stays put
                            if (dec_size <= SIZE_LIMIT) begin
                                grown    = {31'd0, dec_size} * 64'd16 + 64'(d);
                                dec_size = (grown > 64'(SIZE_LIMIT)) ? SIZE_LIMIT + 33'd1
                                                                     : grown[32:0];
                            end
                        end else begin
                            dec_phase = PH_STOP;
                        end
                    end
                end
            end
            ST_DATA: begin
                r.data         = b;
                r.is_data      = 1'b1;
                dec_total      = dec_total + 32'd1;
                dec_chunk_left = dec_chunk_left - 32'd1;
                if (dec_chunk_left == '0) dec_stage = ST_DCR;
            end
            ST_DCR: begin
                if (b == CHAR_CR) begin
                    dec_stage = ST_DLF;
                end else begin
                    dec_stage = ST_MALF;
                    r.status  = STATUS_MALFORM;
                end
            end
            ST_DLF: begin
                if (b == CHAR_LF) begin
                    dec_stage = ST_SIZE;
                    clear_size_line();
                end else begin
                    dec_stage = ST_MALF;
                    r.status  = STATUS_MALFORM;
                end
            end
            ST_TSTART: begin
                if (b == CHAR_CR) begin
                    dec_stage = ST_TCR;
                end else if (b != CHAR_LF) begin
                    dec_stage = ST_TLINE;
                    dec_line  = 14'd1;
                end
            end
            ST_TCR: begin
                if (b == CHAR_LF) begin
                    dec_stage = ST_DONE;
                    r.status  = STATUS_COMPLETE;
                end else begin
                    dec_stage = ST_TLINE;
                    dec_line  = 14'd2;
                end
            end
            ST_TLINE: begin
                if (b == CHAR_LF) begin
                    dec_stage = ST_TSTART;
                    dec_line  = '0;
                end else begin
                    if (dec_line <= TRAILER_LINE_MAX_DEF) dec_line = dec_line + 14'd1;
                    if (dec_line > TRAILER_LINE_MAX_DEF) begin
                        dec_stage = ST_MALF;
                        r.status  = STATUS_MALFORM;
                    end
                end
            end
            ST_DONE:  r.status = STATUS_COMPLETE;
            ST_MALF:  r.status = STATUS_MALFORM;
            ST_LARGE: r.status = STATUS_LARGE;
            default:  r.status = STATUS_IDLE;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic void push_req(input logic start, input logic [7:0] b);
        pending_q.push_back('{start: start, b: b});
        n_queued++;
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
    endfunction

    function automatic void put_crlf();
        body_q.push_back(CHAR_CR);
        body_q.push_back(CHAR_LF);
    endfunction

    function automatic void put_random(input int n);
        repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_size_line(input logic [31:0] sz);
        string h;
        h = $sformatf("%0h", sz);
        if ($urandom_range(0, 1)) h = h.toupper();
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) body_q.push_back(blanks[$urandom_range(0, 4)]);
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) body_q.push_back("0");
        put_text(h);
        case ($urandom_range(0, 3))
            0: put_text(";name=val");
            1: put_text(" ;x");
            default: ;
        endcase
        if ($urandom_range(0, 3) != 0) body_q.push_back(CHAR_CR);
        body_q.push_back(CHAR_LF);
    endfunction

    // Start request, then the built bytes, now and then damaged or cut short
    function automatic void emit_body(input bit may_damage);
        int cut;
        if (may_damage && body_q.size() > 1 && $urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, body_q.size() - 1);
            if ($urandom_range(0, 1)) body_q[cut] = 8'($urandom_range(0, 255));
            else body_q = body_q[0:cut-1];
        end
        push_req(1'b1, 8'($urandom_range(0, 255)));
        foreach (body_q[i]) push_req(1'b0, body_q[i]);
        body_q.delete();
    endfunction

    function automatic void add_trailer_lines();
        repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 10)) body_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
            put_crlf();
        end
        put_crlf();
    endfunction

    function automatic void add_scenario();
        int sz;
        string odd [4] = '{"0x1f", "+3", "-3", "0X2"};
        case ($urandom_range(0, 19))
            12, 13: begin
                // sizes near and past the counter range
                if ($urandom_range(0, 1)) begin
                    put_size_line(32'd1);
                    put_random(1);
                    put_crlf();
                end
                case ($urandom_range(0, 2))
                    0: put_size_line($urandom);
                    1: put_size_line(32'hFFFF_FFFF);
                    default: begin
                        repeat ($urandom_range(9, 12))
                            body_q.push_back(hex_chars[$urandom_range(0, 21)]);
                        body_q.push_back(CHAR_LF);
                    end
                endcase
                put_random($urandom_range(0, 3));
                emit_body(1'b0);
            end
            14: begin
                repeat ($urandom_range(58, 64)) body_q.push_back(blanks[$urandom_range(0, 4)]);
                put_text("1");
                body_q.push_back(CHAR_LF);
                put_random(1);
                put_crlf();
                put_text("0");
                put_crlf();
                put_crlf();
                emit_body(1'b0);
            end
            15: begin
                put_text(odd[$urandom_range(0, 3)]);
                body_q.push_back(CHAR_LF);
                put_random($urandom_range(0, 4));
                emit_body(1'b0);
            end
            16, 17: begin
                repeat ($urandom_range(1, 8)) push_req(1'b0, 8'($urandom_range(0, 255)));
            end
            18: begin
                // payload not followed by CR LF
                sz = $urandom_range(1, 6);
                put_size_line(32'(sz));
                put_random(sz);
                if ($urandom_range(0, 1)) body_q.push_back(CHAR_CR);
                put_random(2);
                emit_body(1'b0);
            end
            default: begin
                repeat ($urandom_range(0, 3)) begin
                    sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12);
                    put_size_line(32'(sz));
                    put_random(sz);
                    put_crlf();
                end
                put_size_line(32'd0);
                add_trailer_lines();
                emit_body(1'b1);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- APB

    task automatic cfg_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_max_body();
        logic [31:0] got;
        cfg_access(1'b0, REG_MAX_BODY, '0, got);
        if (got !== dec_max_body) begin
            $error("max_body readback: expected %08h, got %08h", dec_max_body, got);
            n_fail++;
        end
    endtask

    task automatic write_max_body(input logic [31:0] val);
        logic [31:0] unused;
        cfg_access(1'b1, REG_MAX_BODY, val, unused);
        dec_max_body = val;
        check_max_body();
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_tvalid || exp_result_q.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- request driver

    always @(negedge aclk) begin
        byte_req_t cur;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
            in_gap = 0;
        end else if (!(s_tvalid && !in_taken)) begin
            if (in_taken && !steady) in_gap = pick_gap();
            if (in_gap > 0 || pending_q.size() == 0) begin
                s_tvalid <= 1'b0;
                if (in_gap > 0) in_gap--;
            end else begin
                cur = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= cur.b;
                s_tuser  <= cur.start;
            end
        end
    end

    // ---------------------------------------------------------------- result receiver

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!held_once && n_results >= 150) begin
            // long hold-off so the block backs up onto its input
            held_once = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            if (out_taken && !steady) out_gap = pick_gap();
            if (out_gap > 0) begin
                m_tready <= 1'b0;
                out_gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- prediction and check

    always @(posedge aclk) begin : monitor
        dec_result_t want;
        in_taken  = 1'b0;
        out_taken = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                out_taken = 1'b1;
                n_results++;
                if (exp_result_q.size() == 0) begin
                    $error("result with nothing outstanding: tdata %04h tuser %0b",
                           m_tdata, m_tuser);
                    n_fail++;
                end else begin
                    want = exp_result_q.pop_front();
                    if (m_tdata[7:0] !== want.data) begin
                        $error("data_byte: expected %02h, got %02h", want.data, m_tdata[7:0]);
                        n_fail++;
                    end
                    if (m_tuser !== want.is_data) begin
                        $error("is_data: expected %0b, got %0b", want.is_data, m_tuser);
                        n_fail++;
                    end
                    if (m_tdata[10:8] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[10:8]);
                        n_fail++;
                    end
                    if (m_tdata[15:11] !== 5'd0) begin
                        $error("tdata padding: expected 0, got %02h", m_tdata[15:11]);
                        n_fail++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                exp_result_q.push_back(chunk_decode_step(s_tuser, s_tdata));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------- test sequence

    initial begin
        logic [31:0] limits [7];
        int          target;
        limits = '{32'd0, 32'd24, 32'hFFFF_FFFF, MAX_BODY_RESET, 32'd0, 32'd60, 32'd1};
        limits[4] = $urandom_range(1, 80);
        reset_decoder();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        check_max_body();

        // byte before any start, then one body through blanks, extension and trailer corners
        push_req(1'b0, 8'hFF);
        body_q = '{CHAR_VT, CHAR_FF, CHAR_CR, CHAR_TAB, CHAR_SP};
        put_text("2;x");
        body_q.push_back(CHAR_LF);
        body_q.push_back(8'h00);
        body_q.push_back(8'hFF);
        put_crlf();
        put_text("0");
        body_q.push_back(CHAR_LF);
        body_q.push_back(CHAR_LF);          // bare LF ends a trailer line only
        body_q.push_back(CHAR_CR);          // CR without LF opens an ordinary line
        put_text("X");
        body_q.push_back(CHAR_LF);
        put_crlf();
        put_text("A");                      // ignored once complete
        emit_body(1'b0);
        wait_drained();

        foreach (limits[i]) begin
            write_max_body(limits[i]);
            steady = ($urandom_range(0, 3) == 0);
            target = n_queued + 80;
            while (n_queued < target) add_scenario();
            wait_drained();
        end
        steady = 1'b0;

        repeat (5) @(posedge aclk);
        if (n_fail == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/hcbd_pkg.sv
rtl/hcbd_size_parse.sv
rtl/http_chunked_body_decoder_unit.sv
sim/tb_top.sv
